FILE: src/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: src/bfcs_pkg.sv
// Types, constants and codes shared by the flash command sequencer modules.
package bfcs_pkg;

    localparam int MEM_BYTES = 131072;
    localparam int ADDR_W    = $clog2(MEM_BYTES);
    localparam int ADDR_IN_W = 20;
    localparam int DATA_W    = 8;
    localparam int SECTOR_W  = 13;
    localparam int LOG2_W    = 4;

    localparam logic [ADDR_IN_W-1:0] SEQ_FIRST_ADDR  = 20'h05555;
    localparam logic [ADDR_IN_W-1:0] SEQ_SECOND_ADDR = 20'h0AAAA;
    localparam logic [ADDR_IN_W-1:0] IDENT_MAKER_ADDR  = 20'h00000;
    localparam logic [ADDR_IN_W-1:0] IDENT_DEVICE_ADDR = 20'h00001;
    localparam logic [ADDR_IN_W-1:0] MEM_LIMIT = ADDR_IN_W'(MEM_BYTES);

    localparam logic [DATA_W-1:0] KEY_FIRST   = 8'hAA;
    localparam logic [DATA_W-1:0] KEY_SECOND  = 8'h55;
    localparam logic [DATA_W-1:0] OP_IDENTIFY = 8'h90;
    localparam logic [DATA_W-1:0] OP_PROGRAM  = 8'hA0;
    localparam logic [DATA_W-1:0] OP_LOCK     = 8'hF0;
    localparam logic [DATA_W-1:0] MAKER_CODE  = 8'h1F;
    localparam logic [DATA_W-1:0] ERASED_BYTE = 8'hFF;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic CFG_DEVICE_CODE = 1'b0;
    localparam logic CFG_SECTOR_LOG2 = 1'b1;

    localparam logic [DATA_W-1:0] DEVICE_CODE_RESET = 8'd213;
    localparam logic [LOG2_W-1:0] SECTOR_LOG2_RESET = 4'd7;

    typedef enum logic [2:0] {
        MODE_LOCKED = 3'd0,
        MODE_START1 = 3'd1,
        MODE_START2 = 3'd2,
        MODE_IDENT  = 3'd3,
        MODE_PROG   = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        STS_OK          = 2'd0,
        STS_UNMAPPED    = 2'd1,
        STS_UNPERMITTED = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } ctrl_state_t;

    typedef struct packed {
        logic clear_en;
        logic capture;
        logic execute;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
    } dp_stat_t;

endpackage

FILE: src/bfcs_ctrl.sv
// Controller: erase sweep after reset, word capture, execute and output handshake.
module bfcs_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  bfcs_pkg::dp_stat_t  stat,
    output bfcs_pkg::ctrl_cmd_t cmd
);

    bfcs_pkg::ctrl_state_t state_reg;
    bfcs_pkg::ctrl_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfcs_pkg::S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        out_free       = !out_valid_reg || !out_stall;
        state_next     = state_reg;
        cmd            = '0;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            bfcs_pkg::S_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = bfcs_pkg::S_IDLE;
                end
            end
            bfcs_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = bfcs_pkg::S_EXEC;
                end
            end
            bfcs_pkg::S_EXEC:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    cmd.execute    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = bfcs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bfcs_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: src/bfcs_dp.sv
// Datapath: flash array, mode and sector latch, config registers, result register.
module bfcs_dp
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  bfcs_pkg::ctrl_cmd_t               cmd,
    output bfcs_pkg::dp_stat_t                stat,
    input  logic                              command,
    input  logic [bfcs_pkg::ADDR_IN_W-1:0]    address,
    input  logic [bfcs_pkg::DATA_W-1:0]       write_data,
    input  logic                              cfg_write,
    input  logic                              cfg_index,
    input  logic [bfcs_pkg::DATA_W-1:0]       cfg_data,
    output logic [bfcs_pkg::DATA_W-1:0]       read_data,
    output logic [1:0]                        status
);

    logic [bfcs_pkg::DATA_W-1:0] mem [bfcs_pkg::MEM_BYTES];

    logic [bfcs_pkg::ADDR_W-1:0]    clear_cnt_reg;
    logic [bfcs_pkg::DATA_W-1:0]    device_code_reg;
    logic [bfcs_pkg::LOG2_W-1:0]    sector_log2_reg;
    bfcs_pkg::mode_t                mode_reg;
    bfcs_pkg::mode_t                mode_next;
    logic                           latched_reg;
    logic                           latched_next;
    logic [bfcs_pkg::SECTOR_W-1:0]  sector_reg;
    logic [bfcs_pkg::SECTOR_W-1:0]  sector_next;

    logic                           cmd_reg;
    logic [bfcs_pkg::ADDR_IN_W-1:0] addr_reg;
    logic [bfcs_pkg::DATA_W-1:0]    wdata_reg;
    logic [bfcs_pkg::DATA_W-1:0]    rdata_reg;

    logic [bfcs_pkg::DATA_W-1:0]    read_data_reg;
    logic [bfcs_pkg::DATA_W-1:0]    read_data_next;
    bfcs_pkg::status_t              status_reg;
    bfcs_pkg::status_t              status_next;

    logic                           store;
    logic                           in_range;
    logic                           is_first;
    logic                           is_second;
    logic [bfcs_pkg::SECTOR_W-1:0]  sector;
    logic                           mem_we;
    logic [bfcs_pkg::ADDR_W-1:0]    mem_waddr;
    logic [bfcs_pkg::DATA_W-1:0]    mem_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg   <= '0;
            device_code_reg <= bfcs_pkg::DEVICE_CODE_RESET;
            sector_log2_reg <= bfcs_pkg::SECTOR_LOG2_RESET;
            mode_reg        <= bfcs_pkg::MODE_LOCKED;
            latched_reg     <= 1'b0;
            sector_reg      <= '0;
        end
        else
        begin
            if (cmd.clear_en)
            begin
                clear_cnt_reg <= clear_cnt_reg + 1'b1;
            end
            if (cfg_write)
            begin
                unique case (cfg_index)
                    bfcs_pkg::CFG_DEVICE_CODE: device_code_reg <= cfg_data;
                    bfcs_pkg::CFG_SECTOR_LOG2: sector_log2_reg <= cfg_data[bfcs_pkg::LOG2_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.execute)
            begin
                mode_reg    <= mode_next;
                latched_reg <= latched_next;
                sector_reg  <= sector_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg   <= command;
            addr_reg  <= address;
            wdata_reg <= write_data;
            rdata_reg <= mem[address[bfcs_pkg::ADDR_W-1:0]];
        end
        if (cmd.execute)
        begin
            read_data_reg <= read_data_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_comb
    begin
        in_range  = addr_reg < bfcs_pkg::MEM_LIMIT;
        is_first  = addr_reg == bfcs_pkg::SEQ_FIRST_ADDR;
        is_second = addr_reg == bfcs_pkg::SEQ_SECOND_ADDR;
        sector    = bfcs_pkg::SECTOR_W'(addr_reg >> sector_log2_reg);

        mode_next      = mode_reg;
        latched_next   = latched_reg;
        sector_next    = sector_reg;
        read_data_next = '0;
        status_next    = bfcs_pkg::STS_OK;
        store          = 1'b0;

        if (cmd_reg == bfcs_pkg::CMD_WRITE)
        begin
            if ((mode_reg == bfcs_pkg::MODE_PROG || mode_reg == bfcs_pkg::MODE_IDENT ||
                 mode_reg == bfcs_pkg::MODE_LOCKED) && is_first &&
                wdata_reg == bfcs_pkg::KEY_FIRST)
            begin
                mode_next = bfcs_pkg::MODE_START1;
            end
            else if (mode_reg == bfcs_pkg::MODE_START1 && is_second &&
                     wdata_reg == bfcs_pkg::KEY_SECOND)
            begin
                mode_next = bfcs_pkg::MODE_START2;
            end
            else if (mode_reg == bfcs_pkg::MODE_START2 && is_first &&
                     wdata_reg == bfcs_pkg::OP_IDENTIFY)
            begin
                mode_next = bfcs_pkg::MODE_IDENT;
            end
            else if (mode_reg == bfcs_pkg::MODE_START2 && is_first &&
                     wdata_reg == bfcs_pkg::OP_LOCK)
            begin
                mode_next = bfcs_pkg::MODE_LOCKED;
            end
            else if (mode_reg == bfcs_pkg::MODE_START2 && is_first &&
                     wdata_reg == bfcs_pkg::OP_PROGRAM)
            begin
                mode_next    = bfcs_pkg::MODE_PROG;
                latched_next = 1'b0;
                sector_next  = '0;
            end
            else if (!in_range)
            begin
                status_next = bfcs_pkg::STS_UNMAPPED;
            end
            else if (!latched_reg)
            begin
                // latch the sector of the first data write
                latched_next = 1'b1;
                sector_next  = sector;
                store        = mode_reg == bfcs_pkg::MODE_PROG;
            end
            else if (sector_reg == sector)
            begin
                store = mode_reg == bfcs_pkg::MODE_PROG;
            end
        end
        else if (mode_reg == bfcs_pkg::MODE_IDENT)
        begin
            if (addr_reg == bfcs_pkg::IDENT_MAKER_ADDR)
            begin
                read_data_next = bfcs_pkg::MAKER_CODE;
            end
            else if (addr_reg == bfcs_pkg::IDENT_DEVICE_ADDR)
            begin
                read_data_next = device_code_reg;
            end
            else
            begin
                status_next = bfcs_pkg::STS_UNPERMITTED;
            end
        end
        else if (!in_range)
        begin
            status_next = bfcs_pkg::STS_UNMAPPED;
        end
        else
        begin
            read_data_next = rdata_reg;
        end

        mem_we    = cmd.clear_en || (cmd.execute && store);
        mem_waddr = cmd.clear_en ? clear_cnt_reg : addr_reg[bfcs_pkg::ADDR_W-1:0];
        mem_wdata = cmd.clear_en ? bfcs_pkg::ERASED_BYTE : wdata_reg;
    end

    assign stat.clear_last = clear_cnt_reg == bfcs_pkg::ADDR_W'(bfcs_pkg::MEM_BYTES - 1);
    assign read_data       = read_data_reg;
    assign status          = status_reg;

endmodule

FILE: src/byte_flash_command_sequencer.sv
// Top level of the byte-wide flash command sequencer.
// The array is read at input accept; execute, held until the output register is free, registers the result.
// One word is in flight at a time: the next word is taken only after the previous one executes.
// A new word is taken while the previous result waits in the output register.
// Reset: mode locked, no sector latched, config at defaults; then an erase sweep writes 0xFF
// to all MEM_BYTES (131072) locations of the array with in_stall held high.
`include "assert_macros.svh"

module byte_flash_command_sequencer
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           command,
    input  logic [bfcs_pkg::ADDR_IN_W-1:0] address,
    input  logic [bfcs_pkg::DATA_W-1:0]    write_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [bfcs_pkg::DATA_W-1:0]    read_data,
    output logic [1:0]                     status,
    input  logic                           cfg_write,
    input  logic                           cfg_index,
    input  logic [bfcs_pkg::DATA_W-1:0]    cfg_data
);

    bfcs_pkg::ctrl_cmd_t cmd;
    bfcs_pkg::dp_stat_t  stat;
    logic                in_accept;

    assign in_accept = in_valid && !in_stall;

    bfcs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    bfcs_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .command    (command),
        .address    (address),
        .write_data (write_data),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .read_data  (read_data),
        .status     (status)
    );

    `ASSERT_SAME(a_no_accept_in_clear, clk, rst_n, cmd.clear_en, in_stall)
    `ASSERT_NEXT(a_one_word_in_flight, clk, rst_n, in_accept, in_stall)
    `ASSERT_SAME(a_exec_output_free, clk, rst_n, cmd.execute, !(out_valid && out_stall))
    `ASSERT_NEXT(a_exec_gives_result, clk, rst_n, cmd.execute, out_valid)

endmodule

FILE: verif/byte_flash_command_sequencer_checker.sv
// Bus monitor that tracks the flash array and mode machine and checks every returned word.
`timescale 1ns / 100ps

module byte_flash_command_sequencer_checker
    import bfcs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic                 command,
    input  logic [ADDR_IN_W-1:0] address,
    input  logic [DATA_W-1:0]    write_data,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [DATA_W-1:0]    read_data,
    input  logic [1:0]           status,
    input  logic                 cfg_write,
    input  logic                 cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    output int                   fail_count,
    output int                   pending_count
);

    typedef struct {
        logic [DATA_W-1:0] read_data;
        status_t           status;
    } bus_response_t;

    bus_response_t        bus_responses[$];
    logic [DATA_W-1:0]    flash_image [MEM_BYTES];
    mode_t                seq_mode;
    logic                 sector_held;
    logic [SECTOR_W-1:0]  held_sector;
    logic [DATA_W-1:0]    dev_code;
    logic [LOG2_W-1:0]    sec_log2;

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic apply_bus_access(input logic cmd, input logic [ADDR_IN_W-1:0] addr,
                                    input logic [DATA_W-1:0] data,
                                    output bus_response_t resp);
        logic [SECTOR_W-1:0] sector;
        resp.read_data = '0;
        resp.status    = STS_OK;
        sector         = SECTOR_W'(addr >> sec_log2);
        if (cmd == CMD_WRITE) begin
            if ((seq_mode == MODE_PROG || seq_mode == MODE_IDENT || seq_mode == MODE_LOCKED)
                && addr == SEQ_FIRST_ADDR && data == KEY_FIRST)
            begin
                seq_mode = MODE_START1;
            end
            else if (seq_mode == MODE_START1 && addr == SEQ_SECOND_ADDR && data == KEY_SECOND)
            begin
                seq_mode = MODE_START2;
            end
            else if (seq_mode == MODE_START2 && addr == SEQ_FIRST_ADDR
                     && (data == OP_IDENTIFY || data == OP_LOCK || data == OP_PROGRAM))
            begin
                if (data == OP_IDENTIFY)
                begin
                    seq_mode = MODE_IDENT;
                end
                else if (data == OP_LOCK)
                begin
                    seq_mode = MODE_LOCKED;
                end
                else
                begin
                    seq_mode    = MODE_PROG;
                    sector_held = 1'b0;
                    held_sector = '0;
                end
            end
            else if (addr >= MEM_LIMIT)
            begin
                resp.status = STS_UNMAPPED;
            end
            else if (!sector_held || held_sector == sector)
            begin
                sector_held = 1'b1;
                held_sector = sector;
                if (seq_mode == MODE_PROG)
                    flash_image[addr[ADDR_W-1:0]] = data;
            end
        end
        else if (seq_mode == MODE_IDENT)
        begin
            if (addr == IDENT_MAKER_ADDR)
                resp.read_data = MAKER_CODE;
            else if (addr == IDENT_DEVICE_ADDR)
                resp.read_data = dev_code;
            else
                resp.status = STS_UNPERMITTED;
        end
        else if (addr >= MEM_LIMIT)
        begin
            resp.status = STS_UNMAPPED;
        end
        else
        begin
            resp.read_data = flash_image[addr[ADDR_W-1:0]];
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bus_response_t oldest;
        bus_response_t fresh;
        if (!rst_n)
        begin
            seq_mode    = MODE_LOCKED;
            sector_held = 1'b0;
            held_sector = '0;
            dev_code    = DEVICE_CODE_RESET;
            sec_log2    = SECTOR_LOG2_RESET;
            for (int i = 0; i < MEM_BYTES; i++)
                flash_image[i] = ERASED_BYTE;
            bus_responses.delete();
            fail_count    = 0;
            pending_count = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_DEVICE_CODE)
                    dev_code = cfg_data;
                else
                    sec_log2 = cfg_data[LOG2_W-1:0];
            end
            if (out_valid && !out_stall)
            begin
                if (bus_responses.size() == 0)
                begin
                    report_mismatch("unexpected word, read_data", read_data, '0);
                end
                else
                begin
                    oldest = bus_responses.pop_front();
                    if (read_data !== oldest.read_data)
                        report_mismatch("read_data", read_data, oldest.read_data);
                    if (status !== oldest.status)
                        report_mismatch("status", DATA_W'(status), DATA_W'(oldest.status));
                end
            end
            if (in_valid && !in_stall)
            begin
                apply_bus_access(command, address, write_data, fresh);
                bus_responses.push_back(fresh);
            end
            pending_count = bus_responses.size();
        end
    end

endmodule

FILE: verif/tb_byte_flash_command_sequencer.sv
// Stimulus and verdict for the flash command sequencer: unlock sequences, accesses, config writes, idling.
`timescale 1ns / 100ps

module tb_byte_flash_command_sequencer;
    import bfcs_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int HOLD_OFF_CYCLES = 400;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 command;
    logic [ADDR_IN_W-1:0] address;
    logic [DATA_W-1:0]    write_data;
    logic                 out_valid;
    logic                 out_stall;
    logic [DATA_W-1:0]    read_data;
    logic [1:0]           status;
    logic                 cfg_write;
    logic                 cfg_index;
    logic [DATA_W-1:0]    cfg_data;
    logic                 hold_off_go;
    int                   fail_count;
    int                   pending_count;
    int                   send_idle;
    int                   recv_idle;
    int                   items;
    int                   cycles;

    byte_flash_command_sequencer dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .address    (address),
        .write_data (write_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_data  (read_data),
        .status     (status),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    byte_flash_command_sequencer_checker access_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .address       (address),
        .write_data    (write_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .read_data     (read_data),
        .status        (status),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("byte_flash_command_sequencer verification failed");
        $finish;
    end

    initial
    begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_go && !hold_done)
            begin
                hold_left = HOLD_OFF_CYCLES;
                hold_done = 1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle);
            end
        end
    end

    task automatic issue_access(input logic cmd, input logic [ADDR_IN_W-1:0] addr,
                                input logic [DATA_W-1:0] data);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        address    <= addr;
        write_data <= data;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items++;
    endtask

    task automatic unlock_with(input logic [DATA_W-1:0] op);
        issue_access(CMD_WRITE, SEQ_FIRST_ADDR, KEY_FIRST);
        issue_access(CMD_WRITE, SEQ_SECOND_ADDR, KEY_SECOND);
        issue_access(CMD_WRITE, SEQ_FIRST_ADDR, op);
    endtask

    task automatic set_registers(input logic [DATA_W-1:0] code, input logic [LOG2_W-1:0] lg);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_DEVICE_CODE;
        cfg_data  <= code;
        @(posedge clk);
        cfg_index <= CFG_SECTOR_LOG2;
        cfg_data  <= DATA_W'(lg);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] rand_byte();
        case ($urandom_range(7))
            0:       return KEY_FIRST;
            1:       return KEY_SECOND;
            2:       return OP_IDENTIFY;
            3:       return OP_PROGRAM;
            4:       return OP_LOCK;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [ADDR_IN_W-1:0] rand_address(input int base);
        case ($urandom_range(11))
            0:       return ADDR_IN_W'($urandom_range(1));
            1:       return ADDR_IN_W'($urandom);
            2:       return ADDR_IN_W'($urandom_range(20'hFFFFF, MEM_BYTES));
            3:       return MEM_LIMIT - 1'b1;
            4:       return $urandom_range(1) ? SEQ_FIRST_ADDR : SEQ_SECOND_ADDR;
            5:       return '1;
            default: return ADDR_IN_W'(base + $urandom_range(1023));
        endcase
    endfunction

    task automatic run_random(input int count);
        int               stop;
        int               base;
        int               burst;
        logic [DATA_W-1:0] op;
        stop = items + count;
        base = 0;
        while (items < stop)
        begin
            if ($urandom_range(99) < 50)
            begin
                case ($urandom_range(3))
                    0:       op = OP_IDENTIFY;
                    1:       op = OP_LOCK;
                    default: op = OP_PROGRAM;
                endcase
                base = $urandom_range(MEM_BYTES - 1024);
                issue_access(CMD_WRITE, SEQ_FIRST_ADDR, KEY_FIRST);
                issue_access(CMD_WRITE, SEQ_SECOND_ADDR,
                             ($urandom_range(9) == 0) ? rand_byte() : KEY_SECOND);
                issue_access(CMD_WRITE, SEQ_FIRST_ADDR,
                             ($urandom_range(9) == 0) ? rand_byte() : op);
                burst = $urandom_range(10, 1);
                repeat (burst)
                    issue_access(logic'($urandom_range(1)), rand_address(base), rand_byte());
            end
            else
            begin
                issue_access(logic'($urandom_range(1)), rand_address(base), rand_byte());
            end
        end
    endtask

    initial
    begin
        in_valid    <= 1'b0;
        command     <= CMD_READ;
        address     <= '0;
        write_data  <= '0;
        cfg_write   <= 1'b0;
        cfg_index   <= CFG_DEVICE_CODE;
        cfg_data    <= '0;
        hold_off_go <= 1'b0;
        rst_n       <= 1'b0;
        items     = 0;
        send_idle = 26;
        recv_idle = 79;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        issue_access(CMD_READ, '0, '0);
        issue_access(CMD_READ, MEM_LIMIT - 1'b1, '1);
        issue_access(CMD_READ, MEM_LIMIT, '0);
        issue_access(CMD_READ, '1, '0);
        issue_access(CMD_WRITE, 20'h00100, 8'h00);
        issue_access(CMD_READ, 20'h00100, 8'h00);
        unlock_with(OP_IDENTIFY);
        issue_access(CMD_READ, IDENT_MAKER_ADDR, '0);
        issue_access(CMD_READ, IDENT_DEVICE_ADDR, '0);
        issue_access(CMD_READ, 20'h00002, '0);
        issue_access(CMD_READ, '1, '0);
        issue_access(CMD_WRITE, '1, 8'h00);
        issue_access(CMD_WRITE, SEQ_FIRST_ADDR, KEY_FIRST);
        issue_access(CMD_WRITE, SEQ_SECOND_ADDR, 8'h12);
        issue_access(CMD_WRITE, SEQ_SECOND_ADDR, KEY_SECOND);
        issue_access(CMD_WRITE, SEQ_FIRST_ADDR, OP_PROGRAM);
        issue_access(CMD_WRITE, 20'h00080, 8'h00);
        issue_access(CMD_WRITE, 20'h00081, 8'h34);
        issue_access(CMD_WRITE, 20'h00200, 8'h56);
        issue_access(CMD_WRITE, '1, '1);
        issue_access(CMD_READ, 20'h00080, '0);
        issue_access(CMD_READ, 20'h00081, '0);
        issue_access(CMD_READ, 20'h00200, '0);
        unlock_with(OP_LOCK);
        issue_access(CMD_READ, 20'h00081, '0);

        set_registers(8'h00, 4'd6);
        run_random(510);

        send_idle = 79;
        recv_idle = 26;
        set_registers(8'hFF, 4'd9);
        run_random(510);

        send_idle = 0;
        recv_idle = 0;
        set_registers(DATA_W'($urandom), 4'd8);
        hold_off_go <= 1'b1;
        run_random(500);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("byte_flash_command_sequencer verification clean");
        else
            $display("byte_flash_command_sequencer verification failed");
        $finish;
    end

endmodule

FILE: byte_flash_command_sequencer.f
+incdir+src
src/bfcs_pkg.sv
src/bfcs_ctrl.sv
src/bfcs_dp.sv
src/byte_flash_command_sequencer.sv
verif/byte_flash_command_sequencer_checker.sv
verif/tb_byte_flash_command_sequencer.sv
